// ----- rtl/brcp_pkg.sv -----
// Shared types and constants for the cascaded PID balance controller.
// Used by brcp_ctrl, brcp_datapath and the top level; no dependencies.
package brcp_pkg;

  // Target ramp and integral bounds
  localparam int MAX_FWD_SPEED  = 40;
  localparam int MAX_TURN_SPEED = 30;
  localparam int INTEGRAL_LIMIT = 8000;
  localparam int TURN_STEP      = 20;

  // x/10 = (x * RECIP10) >> RECIP_SHIFT, exact for x < 2^22
  localparam int RECIP10     = 1677722;
  localparam int RECIP_SHIFT = 24;

  // Port widths
  localparam int IN_W       = 88;
  localparam int OUT_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic signed [15:0] MID_ANGLE_RST   = -16'sd512;
  localparam logic signed [31:0] UPRIGHT_KP_RST  = -32'sd13762560;
  localparam logic signed [31:0] UPRIGHT_KD_RST  = -32'sd58982;
  localparam logic signed [31:0] SPEED_KP_RST    = -32'sd22938;
  localparam logic signed [31:0] SPEED_KI_RST    = -32'sd180;
  localparam logic signed [31:0] YAW_KP_HOLD_RST = 32'sd65536;
  localparam logic signed [31:0] YAW_KD_RST      = -32'sd1310720;
  localparam logic [14:0]        PWM_LIMIT_RST   = 15'd7200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MID_ANGLE   = 3'd0,
    REG_UPRIGHT_KP  = 3'd1,
    REG_UPRIGHT_KD  = 3'd2,
    REG_SPEED_KP    = 3'd3,
    REG_SPEED_KI    = 3'd4,
    REG_YAW_KP_HOLD = 3'd5,
    REG_YAW_KD      = 3'd6,
    REG_PWM_LIMIT   = 3'd7
  } reg_idx_t;

  // Operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MS_UPR_P,
    MS_UPR_D,
    MS_DIV10,
    MS_YAW_G,
    MS_YAW_D,
    MS_SPD_P,
    MS_SPD_I,
    MS_FEED
  } mul_sel_t;

  // What the accumulator does with last cycle's product
  typedef enum logic [2:0] {
    AO_HOLD,
    AO_LOAD,
    AO_ADD,
    AO_ADD_SH8,
    AO_SUB,
    AO_FEED
  } acc_op_t;

  typedef struct packed {
    logic     load_in;
    logic     upd_target;
    logic     calc_num;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     cap_v;
    logic     cap_f;
    logic     cap_t;
    logic     cap_w;
    logic     cap_p;
    logic     cap_sum;
    logic     cap_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/brcp_ctrl.sv -----
// Sequencer for the cascaded PID datapath: one step per cycle per tick
// unless the output stalls; needs brcp_pkg's command/status structs.
module brcp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  brcp_pkg::dp_status_t status,
  output brcp_pkg::dp_cmd_t    cmd
);
  import brcp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TGT, ST_NUM,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
    ST_WSAT, ST_M9, ST_M10, ST_P, ST_SUM, ST_OUT
  } state_t;

  state_t state;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (s_tvalid) state <= ST_TGT;
        ST_TGT:  state <= ST_NUM;
        ST_NUM:  state <= ST_M1;
        ST_M1:   state <= ST_M2;
        ST_M2:   state <= ST_M3;
        ST_M3:   state <= ST_M4;
        ST_M4:   state <= ST_M5;
        ST_M5:   state <= ST_M6;
        ST_M6:   state <= ST_M7;
        ST_M7:   state <= ST_M8;
        ST_M8:   state <= ST_WSAT;
        ST_WSAT: state <= ST_M9;
        ST_M9:   state <= ST_M10;
        ST_M10:  state <= ST_P;
        ST_P:    state <= ST_SUM;
        ST_SUM:  state <= ST_OUT;
        ST_OUT:  if (!status.out_busy) state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.mul_sel    = MS_FEED;
    cmd.acc_op     = AO_HOLD;
    unique case (state)
      ST_IDLE: cmd.load_in    = s_tvalid;
      ST_TGT:  cmd.upd_target = 1'b1;
      ST_NUM:  cmd.calc_num   = 1'b1;
      ST_M1:   cmd.mul_sel    = MS_UPR_P;
      ST_M2: begin
        cmd.mul_sel = MS_UPR_D;
        cmd.acc_op  = AO_LOAD;
      end
      ST_M3: begin
        cmd.mul_sel = MS_DIV10;
        cmd.acc_op  = AO_ADD_SH8;
      end
      ST_M4: begin
        cmd.mul_sel = MS_YAW_G;
        cmd.cap_v   = 1'b1;
        cmd.cap_f   = 1'b1;
      end
      ST_M5: begin
        cmd.mul_sel = MS_YAW_D;
        cmd.acc_op  = AO_LOAD;
      end
      ST_M6: begin
        cmd.mul_sel = MS_SPD_P;
        cmd.acc_op  = AO_SUB;
      end
      ST_M7: begin
        cmd.mul_sel = MS_SPD_I;
        cmd.acc_op  = AO_LOAD;
        cmd.cap_t   = 1'b1;
      end
      ST_M8:   cmd.acc_op  = AO_ADD;
      ST_WSAT: cmd.cap_w   = 1'b1;
      ST_M9:   cmd.mul_sel = MS_FEED;
      ST_M10:  cmd.acc_op  = AO_FEED;
      ST_P:    cmd.cap_p   = 1'b1;
      ST_SUM:  cmd.cap_sum = 1'b1;
      ST_OUT:  cmd.cap_out = !status.out_busy;
    endcase
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_out |-> !status.out_busy)
    else $error("result loaded while previous result still pending");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> (state == ST_TGT))
    else $error("accepted tick did not start the sequence");

  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && status.out_busy) |=> (state == ST_OUT))
    else $error("sequencer left final step while output blocked");

endmodule

// ----- rtl/brcp_datapath.sv -----
// Datapath: config registers, loop state, shared 32x32 multiplier,
// accumulator and the output register. Depends on brcp_pkg.
module brcp_datapath #(
  parameter int MAX_FWD_SPEED  = brcp_pkg::MAX_FWD_SPEED,
  parameter int MAX_TURN_SPEED = brcp_pkg::MAX_TURN_SPEED,
  parameter int INTEGRAL_LIMIT = brcp_pkg::INTEGRAL_LIMIT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  brcp_pkg::dp_cmd_t                cmd,
  output brcp_pkg::dp_status_t             status,
  input  logic [brcp_pkg::IN_W-1:0]        s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [brcp_pkg::OUT_W-1:0]       m_tdata,
  input  logic                             cfg_we,
  input  logic [brcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import brcp_pkg::*;

  localparam logic signed [7:0]  FWD_LIM  = 8'(MAX_FWD_SPEED);
  localparam logic signed [7:0]  TURN_LIM = 8'(MAX_TURN_SPEED);
  localparam logic signed [7:0]  TSTEP    = 8'(TURN_STEP);
  localparam logic signed [18:0] INT_LIM  = 19'(INTEGRAL_LIMIT);
  localparam logic signed [65:0] W_MAX    = 66'sd2147483647;

  // truncate toward zero on divide by 2^k
  function automatic logic signed [65:0] trunc_pow2(input logic signed [65:0] x,
                                                    input int unsigned k);
    logic signed [65:0] bias;
    bias = x[65] ? ((66'sd1 <<< k) - 66'sd1) : 66'sd0;
    return (x + bias) >>> k;
  endfunction

  // config registers
  logic signed [15:0] mid_angle;
  logic signed [31:0] upright_kp, upright_kd, speed_kp, speed_ki, yaw_kp_hold, yaw_kd;
  logic        [14:0] pwm_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_angle   <= MID_ANGLE_RST;
      upright_kp  <= UPRIGHT_KP_RST;
      upright_kd  <= UPRIGHT_KD_RST;
      speed_kp    <= SPEED_KP_RST;
      speed_ki    <= SPEED_KI_RST;
      yaw_kp_hold <= YAW_KP_HOLD_RST;
      yaw_kd      <= YAW_KD_RST;
      pwm_limit   <= PWM_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MID_ANGLE:   mid_angle   <= cfg_data[15:0];
        REG_UPRIGHT_KP:  upright_kp  <= cfg_data;
        REG_UPRIGHT_KD:  upright_kd  <= cfg_data;
        REG_SPEED_KP:    speed_kp    <= cfg_data;
        REG_SPEED_KI:    speed_ki    <= cfg_data;
        REG_YAW_KP_HOLD: yaw_kp_hold <= cfg_data;
        REG_YAW_KD:      yaw_kd      <= cfg_data;
        REG_PWM_LIMIT:   pwm_limit   <= cfg_data[14:0];
      endcase
    end
  end

  // input capture
  logic signed [15:0] pitch, pitch_rate, yaw_rate, enc_left, enc_right;
  logic               btn_fwd, btn_rev, btn_left, btn_right;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pitch      <= s_tdata[15:0];
      pitch_rate <= s_tdata[31:16];
      yaw_rate   <= s_tdata[47:32];
      enc_left   <= s_tdata[63:48];
      enc_right  <= s_tdata[79:64];
      btn_fwd    <= s_tdata[80];
      btn_rev    <= s_tdata[81];
      btn_left   <= s_tdata[82];
      btn_right  <= s_tdata[83];
    end
  end

  // target ramps
  logic signed [6:0]  fwd_target, turn_target;
  logic signed [7:0]  ft_next, tt_next;
  logic signed [31:0] yaw_gain;
  logic               any_btn;

  always_comb begin
    ft_next = 8'(fwd_target);
    if (!btn_fwd && !btn_rev) begin
      if (ft_next > 0)      ft_next = ft_next - 8'sd1;
      else if (ft_next < 0) ft_next = ft_next + 8'sd1;
    end
    if (btn_fwd) ft_next = ft_next + 8'sd1;
    if (btn_rev) ft_next = ft_next - 8'sd1;
    if (ft_next > FWD_LIM)       ft_next = FWD_LIM;
    else if (ft_next < -FWD_LIM) ft_next = -FWD_LIM;

    tt_next = 8'(turn_target);
    if (!btn_left && !btn_right) begin
      if (tt_next > 0)      tt_next = tt_next - 8'sd1;
      else if (tt_next < 0) tt_next = tt_next + 8'sd1;
    end
    if (btn_left)  tt_next = tt_next + TSTEP;
    if (btn_right) tt_next = tt_next - TSTEP;
    if (tt_next > TURN_LIM)       tt_next = TURN_LIM;
    else if (tt_next < -TURN_LIM) tt_next = -TURN_LIM;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_target  <= '0;
      turn_target <= '0;
    end else if (cmd.upd_target) begin
      fwd_target  <= ft_next[6:0];
      turn_target <= tt_next[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_target) begin
      yaw_gain <= (!btn_left && !btn_right) ? yaw_kp_hold : 32'sd0;
      any_btn  <= btn_fwd | btn_rev | btn_left | btn_right;
    end
  end

  // speed error numerator 3e + 7*filtered_error, kept as sign/magnitude
  logic signed [17:0] filtered_error;
  logic signed [14:0] error_integral;
  logic signed [17:0] spd_err;
  logic signed [21:0] num;
  logic signed [21:0] num_abs;
  logic               num_neg;
  logic        [20:0] num_mag;

  always_comb begin
    spd_err = 18'(enc_left) + 18'(enc_right) - 18'(fwd_target);
    num     = (22'(spd_err) <<< 1) + 22'(spd_err)
            + (22'(filtered_error) <<< 3) - 22'(filtered_error);
    num_abs = num[21] ? -num : num;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_num) begin
      num_neg <= num[21];
      num_mag <= num_abs[20:0];
    end
  end

  // shared multiplier, product registered
  logic signed [16:0] ang_err;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] w;

  assign ang_err = 17'(pitch) - 17'(mid_angle);

  always_comb begin
    unique case (cmd.mul_sel)
      MS_UPR_P: begin mul_a = upright_kp; mul_b = 32'(ang_err);        end
      MS_UPR_D: begin mul_a = upright_kd; mul_b = 32'(pitch_rate);     end
      MS_DIV10: begin mul_a = {11'b0, num_mag}; mul_b = 32'(RECIP10);  end
      MS_YAW_G: begin mul_a = yaw_gain;   mul_b = 32'(yaw_rate);       end
      MS_YAW_D: begin mul_a = yaw_kd;     mul_b = 32'(turn_target);    end
      MS_SPD_P: begin mul_a = speed_kp;   mul_b = 32'(filtered_error); end
      MS_SPD_I: begin mul_a = speed_ki;   mul_b = 32'(error_integral); end
      MS_FEED:  begin mul_a = upright_kp; mul_b = w;                   end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // accumulator
  logic signed [65:0] acc, prod_x;
  logic signed [33:0] v, t;

  assign prod_x = 66'(prod);

  always_ff @(posedge clk) begin
    unique case (cmd.acc_op)
      AO_HOLD:    acc <= acc;
      AO_LOAD:    acc <= prod_x;
      AO_ADD:     acc <= acc + prod_x;
      AO_ADD_SH8: acc <= acc + (prod_x <<< 8);
      AO_SUB:     acc <= acc - prod_x;
      AO_FEED:    acc <= (66'(v) <<< 16) - prod_x;
      default:    acc <= acc;
    endcase
  end

  // filtered error and clamped integral from the divide-by-ten product
  logic        [16:0] quot;
  logic signed [17:0] f_val;
  logic signed [18:0] s_sum, s_val;

  always_comb begin
    quot  = prod[RECIP_SHIFT+16:RECIP_SHIFT];
    f_val = num_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    s_sum = 19'(error_integral) + 19'(f_val);
    if (s_sum > INT_LIM)       s_val = INT_LIM;
    else if (s_sum < -INT_LIM) s_val = -INT_LIM;
    else                       s_val = s_sum;
    if (any_btn) s_val = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_error <= '0;
      error_integral <= '0;
    end else if (cmd.cap_f) begin
      filtered_error <= f_val;
      error_integral <= s_val[14:0];
    end
  end

  // loop results
  logic signed [65:0] acc_t16;
  logic signed [47:0] p;
  logic signed [49:0] dl, dr;

  assign acc_t16 = trunc_pow2(acc, 16);

  always_ff @(posedge clk) begin
    if (cmd.cap_v) v <= 34'(trunc_pow2(acc, 24));
    if (cmd.cap_t) t <= 34'(acc_t16);
    if (cmd.cap_w) begin
      if (acc_t16 > W_MAX)       w <= 32'(W_MAX);
      else if (acc_t16 < -W_MAX) w <= 32'(-W_MAX);
      else                       w <= 32'(acc_t16);
    end
    if (cmd.cap_p) p <= 48'(acc_t16);
    if (cmd.cap_sum) begin
      dl <= 50'(p) - 50'(t);
      dr <= 50'(p) + 50'(t);
    end
  end

  // saturation and output register
  logic signed [49:0] lim;
  logic signed [15:0] dl_sat, dr_sat, drive_left, drive_right;
  logic               clip, clipped;

  always_comb begin
    lim  = $signed({35'b0, pwm_limit});
    clip = (dl > lim) || (dl < -lim) || (dr > lim) || (dr < -lim);
    if (dl > lim)       dl_sat = 16'(lim);
    else if (dl < -lim) dl_sat = 16'(-lim);
    else                dl_sat = 16'(dl);
    if (dr > lim)       dr_sat = 16'(lim);
    else if (dr < -lim) dr_sat = 16'(-lim);
    else                dr_sat = 16'(dr);
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_out) begin
      drive_left  <= dl_sat;
      drive_right <= dr_sat;
      clipped     <= clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.cap_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata         = {7'b0, clipped, drive_right, drive_left};
  assign status.out_busy = m_tvalid && !m_tready;

  a_int_bound: assert property (@(posedge clk) disable iff (rst)
    (error_integral <= 15'(INTEGRAL_LIMIT)) && (error_integral >= -15'(INTEGRAL_LIMIT)))
    else $error("speed integral out of bounds");

  a_tgt_bound: assert property (@(posedge clk) disable iff (rst)
    (8'(fwd_target) <= FWD_LIM) && (8'(fwd_target) >= -FWD_LIM)
    && (8'(turn_target) <= TURN_LIM) && (8'(turn_target) >= -TURN_LIM))
    else $error("ramp target out of bounds");

  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (17'(drive_left) <= $signed({2'b0, pwm_limit}))
             && (17'(drive_left) >= -$signed({2'b0, pwm_limit}))
             && (17'(drive_right) <= $signed({2'b0, pwm_limit}))
             && (17'(drive_right) >= -$signed({2'b0, pwm_limit})))
    else $error("drive exceeds pwm limit");

  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_out |=> m_tvalid)
    else $error("result loaded but not presented");

endmodule

// ----- rtl/balance_robot_cascaded_pid_top.sv -----
// Top level of the cascaded PID balance controller.
// Instantiates brcp_ctrl and brcp_datapath; depends on brcp_pkg.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------
//  s_*     | in  | s_tvalid / s_tready    | s_tdata: sensor tick + buttons
//  m_*     | out | m_tvalid / m_tready    | m_tdata: drives + clipped flag
//  cfg_*   | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The result is loaded in the last sequencer step after the tick transfer,
// one step per cycle unless the output stalls, from eight products through
// the one shared 32x32 multiplier and their accumulation. The next tick is
// taken in the cycle after the result is loaded. Reset (rst, synchronous)
// loads register defaults and zeroes the targets, filtered error and
// integral. A stalled result holds in the output register; the sequencer
// waits in its last step only if a new result is ready before the previous
// one has been taken.
module balance_robot_cascaded_pid_top #(
  parameter int MAX_FWD_SPEED  = brcp_pkg::MAX_FWD_SPEED,
  parameter int MAX_TURN_SPEED = brcp_pkg::MAX_TURN_SPEED,
  parameter int INTEGRAL_LIMIT = brcp_pkg::INTEGRAL_LIMIT
) (
  input  logic                             clk,
  input  logic                             rst,
  // pitch[15:0], pitch_rate[31:16], yaw_rate[47:32], enc_left[63:48],
  // enc_right[79:64], btn_fwd[80], btn_rev[81], btn_left[82],
  // btn_right[83], zero[87:84]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [brcp_pkg::IN_W-1:0]        s_tdata,
  // drive_left[15:0], drive_right[31:16], clipped[32], zero[39:33]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [brcp_pkg::OUT_W-1:0]       m_tdata,
  // config write channel, always ready
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [brcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import brcp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Registers take a write every cycle; the user must send writes only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  brcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  brcp_datapath #(
    .MAX_FWD_SPEED  (MAX_FWD_SPEED),
    .MAX_TURN_SPEED (MAX_TURN_SPEED),
    .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
